FILE: src/c3zpn_pkg.sv
// ============================================================================
// c3zpn_pkg: shared types and constants for the 3x3 normalized convolution
// Register indexes, input opcodes, kernel geometry and the control bundle
// that travels with each item down the arithmetic pipeline.
// ============================================================================
package c3zpn_pkg;

    // Kernel geometry
    localparam int unsigned KERNEL_DIM   = 3;
    localparam int unsigned NUM_TAPS     = 9;
    localparam int unsigned WEIGHT_BITS  = 4;
    localparam int unsigned KERNEL_BITS  = 36;
    // Nine 4-bit weights sum to at most 135
    localparam int unsigned WSUM_BITS    = 8;

    // Configuration port
    localparam int unsigned CFG_ADDR_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 36;
    localparam int unsigned CFG_DIM_BITS  = 9;

    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KERNEL_WEIGHTS = 2'd2;

    // Image geometry
    localparam int unsigned ROW_BITS   = 9;
    localparam int unsigned HEIGHT_MAX = 256;
    localparam int unsigned DIM_RESET  = 129;

    localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = 36'h111111111;

    // Input opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Control that rides along with each item in the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic wzero;
    } pipe_ctrl_t;

endpackage

FILE: src/c3zpn_window.sv
// ============================================================================
// c3zpn_window: line stores, 3x3 window and raster position tracking
// Takes input items, keeps two line stores and the window, and registers
// one zero-padded neighborhood for every item that completes one.
// ============================================================================
module c3zpn_window #(
    parameter int unsigned MAX_WIDTH = 256,
    parameter int unsigned PIX_W     = 8,
    parameter int unsigned WCW       = 9,
    parameter int unsigned CNTW      = 17
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic                                          s_opcode,
    input  logic [PIX_W-1:0]                              s_pixel_value,
    input  logic [WCW-1:0]                                width_use,
    input  logic [c3zpn_pkg::ROW_BITS-1:0]                height_use,
    input  logic [CNTW-1:0]                               total,
    input  logic                                          out_ready,
    output c3zpn_pkg::pipe_ctrl_t                         out_ctrl,
    output logic [c3zpn_pkg::NUM_TAPS*PIX_W-1:0]          out_win
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned RW   = c3zpn_pkg::ROW_BITS;
    localparam int unsigned TAPS = c3zpn_pkg::NUM_TAPS;
    localparam int unsigned KD   = c3zpn_pkg::KERNEL_DIM;

    // Line stores
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;
    logic [CW-1:0]    rd_addr;
    logic             rd_fwd;

    // Window, stored [column*3 + row], column 2 newest, row 0 top
    logic [PIX_W-1:0] win_reg  [TAPS];
    logic [PIX_W-1:0] win_next [TAPS];

    // Position and result count
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CNTW-1:0] given_reg, given_next;

    // Output stage
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] out_win_reg [TAPS];

    // Per-item decode
    logic             idle_drain;
    logic             take;
    logic             row_ge1;
    logic             row_ge2;
    logic             wrap_res;
    logic             norm_res;
    logic             emit;
    logic             left_en;
    logic             row_wrap;
    logic             last_hit;
    logic             restart;
    logic [PIX_W-1:0] pix_eff;
    logic [WCW-1:0]   col_inc;
    logic [CNTW-1:0]  given_inc;
    logic [PIX_W-1:0] new_col [KD];
    logic [PIX_W-1:0] res_win [TAPS];

    // Accept while the output stage is empty or draining
    assign s_ready = !out_valid_reg || out_ready;

    // Decode the item against the current position and build the neighborhood
    always_comb begin
        idle_drain = (s_opcode == c3zpn_pkg::OP_DRAIN) && (row_reg == '0) &&
                     (col_reg == '0) && (given_reg == '0);
        take       = s_valid && s_ready && !idle_drain;
        row_ge1    = (row_reg != '0);
        row_ge2    = (row_reg >= RW'(2));
        pix_eff    = ((s_opcode != c3zpn_pkg::OP_PIXEL) || (row_reg >= height_use)) ?
                     '0 : s_pixel_value;

        new_col[0] = row_ge2 ? up_rd_reg : '0;
        new_col[1] = row_ge1 ? mid_rd_reg : '0;
        new_col[2] = pix_eff;

        // Row wrap finishes the last column of the row two above
        wrap_res = (col_reg == '0) && row_ge2;
        norm_res = (col_reg != '0) && row_ge1;
        emit     = wrap_res || norm_res;
        left_en  = wrap_res ? (width_use >= WCW'(2)) : (col_reg >= CW'(2));

        for (int r = 0; r < KD; r++) begin
            res_win[r]        = left_en ? win_reg[KD + r] : '0;
            res_win[KD + r]   = win_reg[2*KD + r];
            res_win[2*KD + r] = wrap_res ? '0 : new_col[r];
        end

        col_inc   = WCW'(col_reg) + WCW'(1);
        row_wrap  = (col_inc >= width_use);
        given_inc = given_reg + CNTW'(1);
        last_hit  = (given_inc >= total);
        restart   = emit && last_hit;

        // Advance position, window and count
        col_next   = col_reg;
        row_next   = row_reg;
        given_next = given_reg;
        for (int k = 0; k < TAPS; k++) begin
            win_next[k] = win_reg[k];
        end
        if (take) begin
            if (restart) begin
                col_next   = '0;
                row_next   = '0;
                given_next = '0;
                for (int k = 0; k < TAPS; k++) begin
                    win_next[k] = '0;
                end
            end else begin
                col_next   = row_wrap ? '0 : col_inc[CW-1:0];
                row_next   = row_wrap ? row_reg + RW'(1) : row_reg;
                given_next = emit ? given_inc : given_reg;
                for (int k = 0; k < 2*KD; k++) begin
                    win_next[k] = win_reg[k + KD];
                end
                for (int r = 0; r < KD; r++) begin
                    win_next[2*KD + r] = new_col[r];
                end
            end
        end

        // Prefetch the column the next item lands on
        rd_addr = aresetn ? col_next : '0;
        rd_fwd  = take && (col_next == col_reg);
    end

    // Position, count and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            given_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            given_reg <= given_next;
            for (int k = 0; k < TAPS; k++) begin
                win_reg[k] <= win_next[k];
            end
            if (s_ready) begin
                out_valid_reg <= take && emit;
            end
        end
    end

    // Hold the neighborhood for the next stage
    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_last_reg <= last_hit;
            for (int k = 0; k < TAPS; k++) begin
                out_win_reg[k] <= res_win[k];
            end
        end
    end

    // Line stores: shift the column down one line, bypass a same-column read
    always_ff @(posedge aclk) begin
        if (take) begin
            upper_mem[col_reg]  <= mid_rd_reg;
            middle_mem[col_reg] <= pix_eff;
        end
        up_rd_reg  <= rd_fwd ? mid_rd_reg : upper_mem[rd_addr];
        mid_rd_reg <= rd_fwd ? pix_eff : middle_mem[rd_addr];
    end

    assign out_ctrl = '{valid: out_valid_reg, last: out_last_reg, wzero: 1'b0};

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            out_win[k*PIX_W +: PIX_W] = out_win_reg[k];
        end
    end

endmodule

FILE: src/c3zpn_mac.sv
// ============================================================================
// c3zpn_mac: weighted sum of the 3x3 neighborhood
// Stage one forms the nine products and the weight sum, stage two adds the
// products into the dividend.
// ============================================================================
module c3zpn_mac #(
    parameter int unsigned PIX_W = 8,
    parameter int unsigned ACC_W = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  c3zpn_pkg::pipe_ctrl_t                    in_ctrl,
    input  logic [c3zpn_pkg::NUM_TAPS*PIX_W-1:0]     in_win,
    input  logic [c3zpn_pkg::KERNEL_BITS-1:0]        kernel,
    output logic                                     in_ready,
    input  logic                                     out_ready,
    output c3zpn_pkg::pipe_ctrl_t                    out_ctrl,
    output logic [ACC_W-1:0]                         out_acc,
    output logic [c3zpn_pkg::WSUM_BITS-1:0]          out_wsum
);

    localparam int unsigned TAPS   = c3zpn_pkg::NUM_TAPS;
    localparam int unsigned KD     = c3zpn_pkg::KERNEL_DIM;
    localparam int unsigned WB     = c3zpn_pkg::WEIGHT_BITS;
    localparam int unsigned SW     = c3zpn_pkg::WSUM_BITS;
    localparam int unsigned PROD_W = PIX_W + WB;

    logic [PROD_W-1:0]     prod_reg  [TAPS];
    logic [PROD_W-1:0]     prod_next [TAPS];
    logic [SW-1:0]         wsum1_reg, wsum_next, wsum2_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    c3zpn_pkg::pipe_ctrl_t ctrl1_reg, ctrl2_reg;
    logic                  rdy1, rdy2;

    // Advance each stage when it is empty or the one after moves
    assign rdy2     = !ctrl2_reg.valid || out_ready;
    assign rdy1     = !ctrl1_reg.valid || rdy2;
    assign in_ready = rdy1;

    // Products: weight r*3+c meets window pixel c*3+r
    always_comb begin
        wsum_next = '0;
        for (int r = 0; r < KD; r++) begin
            for (int c = 0; c < KD; c++) begin
                prod_next[r*KD + c] =
                    PROD_W'(kernel[(r*KD + c)*WB +: WB]) *
                    PROD_W'(in_win[(c*KD + r)*PIX_W +: PIX_W]);
                wsum_next = wsum_next + SW'(kernel[(r*KD + c)*WB +: WB]);
            end
        end
    end

    // Sum the products
    always_comb begin
        acc_next = '0;
        for (int k = 0; k < TAPS; k++) begin
            acc_next = acc_next + ACC_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else begin
            if (rdy1) begin
                ctrl1_reg <= '{valid: in_ctrl.valid, last: in_ctrl.last,
                               wzero: (wsum_next == '0)};
            end
            if (rdy2) begin
                ctrl2_reg <= ctrl1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_ctrl.valid) begin
            wsum1_reg <= wsum_next;
            for (int k = 0; k < TAPS; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (rdy2 && ctrl1_reg.valid) begin
            acc_reg   <= acc_next;
            wsum2_reg <= wsum1_reg;
        end
    end

    assign out_ctrl = ctrl2_reg;
    assign out_acc  = acc_reg;
    assign out_wsum = wsum2_reg;

endmodule

FILE: src/c3zpn_div_cell.sv
// ============================================================================
// c3zpn_div_cell: one restoring-division step
// Compares the running remainder with the aligned divisor, settles one
// quotient bit and hands remainder, divisor and quotient to the next cell.
// ============================================================================
module c3zpn_div_cell #(
    parameter int unsigned PIX_W = 8,
    parameter int unsigned ACC_W = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  c3zpn_pkg::pipe_ctrl_t in_ctrl,
    input  logic [ACC_W-1:0]      in_rem,
    input  logic [ACC_W-1:0]      in_dsh,
    input  logic [PIX_W-1:0]      in_quot,
    output logic                  in_ready,
    input  logic                  out_ready,
    output c3zpn_pkg::pipe_ctrl_t out_ctrl,
    output logic [ACC_W-1:0]      out_rem,
    output logic [ACC_W-1:0]      out_dsh,
    output logic [PIX_W-1:0]      out_quot
);

    c3zpn_pkg::pipe_ctrl_t ctrl_reg;
    logic [ACC_W-1:0]      rem_reg, dsh_reg, rem_next;
    logic [PIX_W-1:0]      quot_reg;
    logic [PIX_W:0]        quot_shift;
    logic                  ge;

    assign in_ready = !ctrl_reg.valid || out_ready;

    // Subtract the aligned divisor when it fits
    always_comb begin
        ge         = (in_rem >= in_dsh);
        rem_next   = ge ? (in_rem - in_dsh) : in_rem;
        quot_shift = {in_quot, ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (in_ready) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctrl.valid) begin
            rem_reg  <= rem_next;
            dsh_reg  <= in_dsh >> 1;
            quot_reg <= quot_shift[PIX_W-1:0];
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_rem  = rem_reg;
    assign out_dsh  = dsh_reg;
    assign out_quot = quot_reg;

endmodule

FILE: src/conv3x3_zero_pad_normalized.sv
// ============================================================================
// conv3x3_zero_pad_normalized: streaming 3x3 weighted box filter
// Raster pixels in, each pixel's zero-padded weighted neighborhood sum
// divided by the weight sum out, one row and one pixel behind.
// ============================================================================
//
//  channel   ports                                           direction
//  --------  ----------------------------------------------  ---------
//  input     s_valid s_ready s_opcode s_pixel_value          in
//  result    m_valid m_ready m_filtered_pixel
//            m_last_of_image m_weight_sum_zero               out
//  config    cfg_wr_en cfg_addr cfg_wdata                    in
//
//  One item is taken per clock while s_ready is high. After the item that
//  completes its window, a result passes the window register, product and sum
//  stages, then a chain of PIXEL_BITS division cells, one quotient bit each.
//  Reset clears position, count, window and pipeline control; line stores
//  are not cleared and need no clearing pass.
//  m_ready low stalls the chain from the back; empty stages still fill.
// ============================================================================
module conv3x3_zero_pad_normalized #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_opcode,
    input  logic [PIXEL_BITS-1:0]                  s_pixel_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [PIXEL_BITS-1:0]                  m_filtered_pixel,
    output logic                                   m_last_of_image,
    output logic                                   m_weight_sum_zero,
    input  logic                                   cfg_wr_en,
    input  logic [c3zpn_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [c3zpn_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int unsigned RW    = c3zpn_pkg::ROW_BITS;
    localparam int unsigned DW    = c3zpn_pkg::CFG_DIM_BITS;
    localparam int unsigned WCW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CNTW  = $clog2(MAX_WIDTH * c3zpn_pkg::HEIGHT_MAX + 1);
    localparam int unsigned ACC_W = PIXEL_BITS + c3zpn_pkg::WSUM_BITS;
    localparam int unsigned CLW   = WCW + DW;
    localparam int unsigned AW    = WCW + RW;
    localparam int unsigned WIDTH_RESET =
        (MAX_WIDTH < c3zpn_pkg::DIM_RESET) ? MAX_WIDTH : c3zpn_pkg::DIM_RESET;
    localparam int unsigned TOTAL_RESET = WIDTH_RESET * c3zpn_pkg::DIM_RESET;

    // Configuration, kept clamped
    logic [WCW-1:0]                      width_use_reg, width_next;
    logic [RW-1:0]                       height_use_reg, height_next;
    logic [CNTW-1:0]                     total_reg, total_next;
    logic [c3zpn_pkg::KERNEL_BITS-1:0]   kernel_reg, kernel_next;
    logic [DW-1:0]                       dim_raw;
    logic [AW-1:0]                       area;

    // Pipeline links
    c3zpn_pkg::pipe_ctrl_t                        win_ctrl;
    logic [c3zpn_pkg::NUM_TAPS*PIXEL_BITS-1:0]    win_data;
    logic                                         mac_in_ready;
    c3zpn_pkg::pipe_ctrl_t                        mac_ctrl;
    logic [ACC_W-1:0]                             mac_acc;
    logic [c3zpn_pkg::WSUM_BITS-1:0]              mac_wsum;

    c3zpn_pkg::pipe_ctrl_t ctrl_c [PIXEL_BITS+1];
    logic [ACC_W-1:0]      rem_c  [PIXEL_BITS+1];
    logic [ACC_W-1:0]      dsh_c  [PIXEL_BITS+1];
    logic [PIXEL_BITS-1:0] quot_c [PIXEL_BITS+1];
    logic                  rdy_c  [PIXEL_BITS+1];

    // Decode register writes and clamp the image size
    always_comb begin
        dim_raw     = cfg_wdata[DW-1:0];
        width_next  = width_use_reg;
        height_next = height_use_reg;
        kernel_next = kernel_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                c3zpn_pkg::REG_IMAGE_WIDTH: begin
                    if (dim_raw == '0) begin
                        width_next = WCW'(1);
                    end else if (CLW'(dim_raw) > CLW'(MAX_WIDTH)) begin
                        width_next = WCW'(MAX_WIDTH);
                    end else begin
                        width_next = WCW'(dim_raw);
                    end
                end
                c3zpn_pkg::REG_IMAGE_HEIGHT: begin
                    if (dim_raw == '0) begin
                        height_next = RW'(1);
                    end else if (dim_raw > DW'(c3zpn_pkg::HEIGHT_MAX)) begin
                        height_next = RW'(c3zpn_pkg::HEIGHT_MAX);
                    end else begin
                        height_next = RW'(dim_raw);
                    end
                end
                c3zpn_pkg::REG_KERNEL_WEIGHTS: begin
                    kernel_next = cfg_wdata[c3zpn_pkg::KERNEL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
        area       = AW'(width_next) * AW'(height_next);
        total_next = area[CNTW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_use_reg  <= WCW'(WIDTH_RESET);
            height_use_reg <= RW'(c3zpn_pkg::DIM_RESET);
            total_reg      <= CNTW'(TOTAL_RESET);
            kernel_reg     <= c3zpn_pkg::KERNEL_RESET;
        end else begin
            width_use_reg  <= width_next;
            height_use_reg <= height_next;
            total_reg      <= total_next;
            kernel_reg     <= kernel_next;
        end
    end

    // Window and line stores
    c3zpn_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIX_W     (PIXEL_BITS),
        .WCW       (WCW),
        .CNTW      (CNTW)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_pixel_value (s_pixel_value),
        .width_use     (width_use_reg),
        .height_use    (height_use_reg),
        .total         (total_reg),
        .out_ready     (mac_in_ready),
        .out_ctrl      (win_ctrl),
        .out_win       (win_data)
    );

    // Weighted sum
    c3zpn_mac #(
        .PIX_W (PIXEL_BITS),
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (win_ctrl),
        .in_win    (win_data),
        .kernel    (kernel_reg),
        .in_ready  (mac_in_ready),
        .out_ready (rdy_c[0]),
        .out_ctrl  (mac_ctrl),
        .out_acc   (mac_acc),
        .out_wsum  (mac_wsum)
    );

    // Feed the division chain: divisor aligned to the top quotient bit
    assign ctrl_c[0] = mac_ctrl;
    assign rem_c[0]  = mac_acc;
    assign dsh_c[0]  = ACC_W'(mac_wsum) << (PIXEL_BITS - 1);
    assign quot_c[0] = '0;
    assign rdy_c[PIXEL_BITS] = !ctrl_c[PIXEL_BITS].valid || m_ready;

    for (genvar k = 0; k < PIXEL_BITS; k++) begin : g_cell
        c3zpn_div_cell #(
            .PIX_W (PIXEL_BITS),
            .ACC_W (ACC_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctrl   (ctrl_c[k]),
            .in_rem    (rem_c[k]),
            .in_dsh    (dsh_c[k]),
            .in_quot   (quot_c[k]),
            .in_ready  (rdy_c[k]),
            .out_ready (rdy_c[k+1]),
            .out_ctrl  (ctrl_c[k+1]),
            .out_rem   (rem_c[k+1]),
            .out_dsh   (dsh_c[k+1]),
            .out_quot  (quot_c[k+1])
        );
    end

    // Zero weight sum forces a zero result
    assign m_valid           = ctrl_c[PIXEL_BITS].valid;
    assign m_last_of_image   = ctrl_c[PIXEL_BITS].last;
    assign m_weight_sum_zero = ctrl_c[PIXEL_BITS].wzero;
    assign m_filtered_pixel  = ctrl_c[PIXEL_BITS].wzero ? '0 : quot_c[PIXEL_BITS];

    // Clamped image size stays in range
    a_dims_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (width_use_reg != '0) && (WCW'(width_use_reg) <= WCW'(MAX_WIDTH)) &&
        (height_use_reg != '0) && (height_use_reg <= RW'(c3zpn_pkg::HEIGHT_MAX)))
        else $error("image size register out of range");

    // Pixel total tracks the registered size
    a_total_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (AW'(total_reg) == AW'(width_use_reg) * AW'(height_use_reg)))
        else $error("pixel total out of step with image size");

    // An empty result port never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

endmodule
